// File: hdl/assert_macros.svh
// assertion macros shared by the array list engine rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checks off while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checks off while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/oal_pkg.sv
// shared constants, codes and record type of the ordered array list engine
// no dependencies; used by the top level and its checks
package oal_pkg;

   localparam int CAPACITY  = 16;
   localparam int KEY_BITS  = 64;
   localparam int DATA_W    = 32;
   localparam int IDX_W     = $clog2(CAPACITY);
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int ACT_W     = 3;
   localparam int ST_W      = 2;
   localparam int POS_W     = 4;
   localparam int OUT_IDX_W = 4;
   localparam int OUT_CNT_W = 5;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(CAPACITY);

   typedef enum logic [ACT_W-1:0] {
      ACT_APPEND     = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_INSERT_AT  = 3'd2,
      ACT_REMOVE_AT  = 3'd3,
      ACT_REMOVE_KEY = 3'd4,
      ACT_UPDATE_KEY = 3'd5,
      ACT_FIND       = 3'd6
   } action_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef struct packed {
      logic [KEY_BITS-1:0] key;
      logic [DATA_W-1:0]   size;
      logic [DATA_W-1:0]   date;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

endpackage

// File: hdl/oal_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies; holds the record array of the list engine
module oal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ordered_array_list_engine.sv
// append, errors, empty search and unused codes answer straight from idle; insert before p
// (front is p = 0) shifts entries p..count-1 up, remove at p shifts the entries behind p down
// (none for the last entry), find or update scan from entry 0 to a hit or the tail, remove key scans then shifts.
// one item at a time, the next accepted in the result cycle; one ram entry moves per cycle.
// synchronous reset clears count and control, not the record ram; the receiver cannot stall.
// depends on oal_pkg, oal_ram and assert_macros.svh
`include "assert_macros.svh"

module ordered_array_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_position,
   input  logic [63:0] req_record_key,
   input  logic [63:0] req_match_key,
   input  logic [31:0] req_record_size,
   input  logic [31:0] req_record_date,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_found_index,
   output logic [4:0]  rsp_entry_count
);

   localparam int IW = oal_pkg::IDX_W;
   localparam int CW = oal_pkg::CNT_W;
   localparam int KW = oal_pkg::KEY_BITS;
   localparam int PW = oal_pkg::CMP_W;
   localparam int OI = oal_pkg::OUT_IDX_W;
   localparam int OC = oal_pkg::OUT_CNT_W;

   typedef enum logic [3:0] {
      S_IDLE     = 4'b0001,
      S_SEARCH   = 4'b0010,
      S_SHIFT_UP = 4'b0100,
      S_SHIFT_DN = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   oal_pkg::action_type    act_ff, act_in;
   logic [IW-1:0]          pos_ff, pos_in;
   oal_pkg::rec_type       rec_ff, rec_in;
   logic [KW-1:0]          skey_ff, skey_in;
   logic [CW-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                   iss_ff, iss_in;
   logic                   dvld_ff, dvld_in;
   logic [IW-1:0]          daddr_ff, daddr_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   oal_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [OI-1:0]          rsp_idx_ff, rsp_idx_in;
   logic [OC-1:0]          rsp_cnt_ff, rsp_cnt_in;

   logic                   ram_wr_en;
   logic [IW-1:0]          ram_wr_addr;
   oal_pkg::rec_type       ram_wr_rec;
   logic                   ram_rd_en;
   logic [IW-1:0]          ram_rd_addr;
   logic [oal_pkg::REC_W-1:0] ram_rd_raw;
   oal_pkg::rec_type       ram_rd_rec;

   oal_pkg::action_type    act;
   oal_pkg::rec_type       req_rec;
   logic                   is_full;
   logic                   pos_ok;
   logic [CW-1:0]          cnt_inc;
   logic [CW-1:0]          cnt_dec;
   logic [CW-1:0]          ptr_inc;
   logic [CW-1:0]          rm_start;
   logic                   take_append;
   logic                   full_reply;

   oal_ram #(
      .WIDTH (oal_pkg::REC_W),
      .DEPTH (oal_pkg::CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_rec),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_rec = oal_pkg::rec_type'(ram_rd_raw);

   assign act          = oal_pkg::action_type'(req_action);
   assign req_rec.key  = req_record_key[KW-1:0];
   assign req_rec.size = req_record_size;
   assign req_rec.date = req_record_date;
   assign is_full      = (count_ff == oal_pkg::FULL_COUNT);
   assign pos_ok       = (PW'(req_position) < PW'(count_ff));
   assign cnt_inc      = count_ff + 1'b1;
   assign cnt_dec      = count_ff - 1'b1;
   assign ptr_inc      = rd_ptr_ff + 1'b1;
   assign rm_start     = CW'(req_position) + 1'b1;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      act_in        = act_ff;
      pos_in        = pos_ff;
      rec_in        = rec_ff;
      skey_in       = skey_ff;
      rd_ptr_in     = rd_ptr_ff;
      iss_in        = iss_ff;
      dvld_in       = 1'b0;
      daddr_in      = rd_ptr_ff[IW-1:0];
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_rec    = rec_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_ptr_ff[IW-1:0];

      case (state_ff)
         S_IDLE: begin
            iss_in = 1'b0;
            if (start) begin
               act_in  = act;
               rec_in  = req_rec;
               skey_in = (act == oal_pkg::ACT_UPDATE_KEY) ? req_match_key[KW-1:0]
                                                          : req_record_key[KW-1:0];
               // answer of an item that ends here; overridden below where it does not
               rsp_valid_in  = 1'b1;
               rsp_status_in = oal_pkg::ST_OK;
               rsp_idx_in    = '0;
               rsp_cnt_in    = OC'(count_ff);
               case (act)
                  oal_pkg::ACT_APPEND: begin
                     if (is_full) begin
                        rsp_status_in = oal_pkg::ST_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[IW-1:0];
                        ram_wr_rec  = req_rec;
                        count_in    = cnt_inc;
                        rsp_idx_in  = OI'(count_ff);
                        rsp_cnt_in  = OC'(cnt_inc);
                     end
                  end
                  oal_pkg::ACT_PUSH_FRONT, oal_pkg::ACT_INSERT_AT: begin
                     if (is_full) begin
                        rsp_status_in = oal_pkg::ST_FULL;
                     end else if (act == oal_pkg::ACT_INSERT_AT && !pos_ok) begin
                        rsp_status_in = oal_pkg::ST_RANGE;
                     end else if (count_ff == '0) begin
                        // front insert into an empty list needs no shift
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = '0;
                        ram_wr_rec  = req_rec;
                        count_in    = cnt_inc;
                        rsp_cnt_in  = OC'(cnt_inc);
                     end else begin
                        rsp_valid_in = 1'b0;
                        pos_in       = (act == oal_pkg::ACT_PUSH_FRONT) ? '0
                                                                        : IW'(req_position);
                        rd_ptr_in    = cnt_dec;
                        iss_in       = 1'b1;
                        state_in     = S_SHIFT_UP;
                     end
                  end
                  oal_pkg::ACT_REMOVE_AT: begin
                     if (!pos_ok) begin
                        rsp_status_in = oal_pkg::ST_RANGE;
                     end else begin
                        rsp_valid_in = 1'b0;
                        pos_in       = IW'(req_position);
                        rd_ptr_in    = rm_start;
                        iss_in       = (rm_start < count_ff);
                        state_in     = S_SHIFT_DN;
                     end
                  end
                  oal_pkg::ACT_REMOVE_KEY, oal_pkg::ACT_UPDATE_KEY, oal_pkg::ACT_FIND: begin
                     if (count_ff == '0) begin
                        rsp_status_in = oal_pkg::ST_MISSING;
                     end else begin
                        rsp_valid_in = 1'b0;
                        rd_ptr_in    = '0;
                        iss_in       = 1'b1;
                        state_in     = S_SEARCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // read entry j, write it to j+1 in the next cycle, walking down to the hole
            if (iss_ff) begin
               ram_rd_en = 1'b1;
               if (rd_ptr_ff[IW-1:0] == pos_ff) begin
                  iss_in = 1'b0;
               end else begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end
            end
            dvld_in = iss_ff;
            if (dvld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = daddr_ff + 1'b1;
               ram_wr_rec  = ram_rd_rec;
            end else if (!iss_ff) begin
               ram_wr_en     = 1'b1;
               ram_wr_addr   = pos_ff;
               ram_wr_rec    = rec_ff;
               count_in      = cnt_inc;
               rsp_valid_in  = 1'b1;
               rsp_status_in = oal_pkg::ST_OK;
               rsp_idx_in    = OI'(pos_ff);
               rsp_cnt_in    = OC'(cnt_inc);
               state_in      = S_IDLE;
            end
         end

         S_SHIFT_DN: begin
            // read entry j, write it to j-1 in the next cycle, walking up to the tail
            if (iss_ff) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = ptr_inc;
               iss_in    = (ptr_inc < count_ff);
            end
            dvld_in = iss_ff;
            if (dvld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = daddr_ff - 1'b1;
               ram_wr_rec  = ram_rd_rec;
            end else if (!iss_ff) begin
               count_in      = cnt_dec;
               rsp_valid_in  = 1'b1;
               rsp_status_in = oal_pkg::ST_OK;
               rsp_idx_in    = OI'(pos_ff);
               rsp_cnt_in    = OC'(cnt_dec);
               state_in      = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (iss_ff) begin
               ram_rd_en = 1'b1;
               rd_ptr_in = ptr_inc;
               iss_in    = (ptr_inc < count_ff);
            end
            dvld_in = iss_ff;
            if (dvld_ff) begin
               if (ram_rd_rec.key == skey_ff) begin
                  iss_in  = 1'b0;
                  dvld_in = 1'b0;
                  case (act_ff)
                     oal_pkg::ACT_REMOVE_KEY: begin
                        // restart the read pointer just past the hit
                        pos_in    = daddr_ff;
                        rd_ptr_in = CW'(daddr_ff) + 1'b1;
                        iss_in    = ((CW'(daddr_ff) + 1'b1) < count_ff);
                        state_in  = S_SHIFT_DN;
                     end
                     oal_pkg::ACT_UPDATE_KEY: begin
                        ram_wr_en     = 1'b1;
                        ram_wr_addr   = daddr_ff;
                        ram_wr_rec    = rec_ff;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_OK;
                        rsp_idx_in    = OI'(daddr_ff);
                        rsp_cnt_in    = OC'(count_ff);
                        state_in      = S_IDLE;
                     end
                     default: begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = oal_pkg::ST_OK;
                        rsp_idx_in    = OI'(daddr_ff);
                        rsp_cnt_in    = OC'(count_ff);
                        state_in      = S_IDLE;
                     end
                  endcase
               end else if (!iss_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = oal_pkg::ST_MISSING;
                  rsp_idx_in    = '0;
                  rsp_cnt_in    = OC'(count_ff);
                  state_in      = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
            iss_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         iss_ff       <= 1'b0;
         dvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         dvld_ff      <= dvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      rec_ff        <= rec_in;
      skey_ff       <= skey_in;
      rd_ptr_ff     <= rd_ptr_in;
      daddr_ff      <= daddr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_index = rsp_idx_ff;
   assign rsp_entry_count = rsp_cnt_ff;

   assign take_append = start && !busy && (act == oal_pkg::ACT_APPEND);
   assign full_reply  = rsp_strobe && (rsp_status_ff == oal_pkg::ST_FULL);

   `ASSERT_NEXT(a_append_one_cycle, clock, reset, take_append, rsp_strobe)
   `ASSERT_IMPLY(a_strobe_when_idle, clock, reset, rsp_strobe, !busy)
   `ASSERT_IMPLY(a_full_means_full, clock, reset, full_reply, is_full)
   `ASSERT_IMPLY(a_no_rw_overlap, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)

endmodule
